>>> src/svpd_pkg.sv
package svpd_pkg;

    localparam int SIN_W = 17;
    localparam int MAG_W = 16;
    localparam int PROD_W = SIN_W + MAG_W;
    localparam int SCL_W = 25;
    localparam int ACT_W = 26;
    localparam int DUTY2_W = 18;

    localparam logic [SIN_W-1:0] ONE_Q16 = 17'h10000;
    localparam logic [16:0] SQRT3_Q16 = 17'd113512;
    localparam logic [31:0] PI_Q30 = 32'd3373259426;

    localparam logic REG_INV_SUPPLY = 1'b0;
    localparam logic REG_CARRIER_PERIOD = 1'b1;

    localparam logic [15:0] INV_SUPPLY_RST = 16'd5461;
    localparam logic [15:0] CARRIER_PERIOD_RST = 16'd1000;

    typedef enum logic [2:0] {
        SEC_1 = 3'd0,
        SEC_2 = 3'd1,
        SEC_3 = 3'd2,
        SEC_4 = 3'd3,
        SEC_5 = 3'd4,
        SEC_6 = 3'd5
    } sector_t;

    typedef struct packed {
        logic signed [15:0] uq;
        logic [15:0]        angle;
    } svpd_cmd_t;

    typedef struct packed {
        logic [15:0] duty_a;
        logic [15:0] duty_b;
        logic [15:0] duty_c;
    } svpd_duty_t;

    typedef struct packed {
        logic [15:0] inv_supply;
        logic [15:0] carrier_period;
    } svpd_cfg_t;

    typedef struct packed {
        sector_t           sector;
        logic [MAG_W-1:0]  mag;
        logic [SIN_W-1:0]  sin_t1;
        logic [SIN_W-1:0]  sin_t2;
    } svpd_sine_t;

    typedef struct packed {
        sector_t           sector;
        logic [ACT_W-1:0]  t1;
        logic [ACT_W-1:0]  t2;
    } svpd_act_t;

endpackage

>>> src/space_vector_pwm_duty_core.sv
// Space-vector PWM duty core.
// cmd channel (in_valid/in_ready): one word holds the signed Q8.8 voltage uq and the
// electrical angle; a negative voltage flips the angle by half a turn.
// duty channel (out_valid/out_ready): one word holds the three phase compare values,
// each from 0 to carrier_period.
// Config port: cfg_we writes cfg_data to register cfg_index (0 = inv_supply,
// 1 = carrier_period) on the same edge; write only while no word is in flight.
// Pipeline: an accepted cmd word passes ten registered stages to its duty word
// (1 fold, 4 sine lookup and interpolation, 3 multiply, 2 duty/scale stages).
// Throughput: one word per cycle, set by the ten-stage pipeline, while the
// receiver keeps out_ready high.
// A stalled receiver holds the duty word; the stages behind it keep filling
// bubbles and in_ready drops only once every stage holds a word.
// Reset empties the pipeline and loads inv_supply = 5461 and carrier_period = 1000.
module space_vector_pwm_duty_core #(
    parameter int SINE_TABLE_DEPTH = 256,
    parameter int ANGLE_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic                    cfg_index,
    input  logic [15:0]             cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  svpd_pkg::svpd_cmd_t     cmd,
    output logic                    out_valid,
    input  logic                    out_ready,
    output svpd_pkg::svpd_duty_t    duty
);
    import svpd_pkg::*;

    logic [15:0] inv_supply_reg;
    logic [15:0] carrier_period_reg;
    svpd_cfg_t   cfg;

    logic                  fold_valid, fold_ready;
    sector_t               fold_sector;
    logic [ANGLE_BITS-1:0] fold_r;
    logic [15:0]           fold_mag;
    logic                  sine_valid, sine_ready;
    svpd_sine_t            sine_word;
    logic                  act_valid, act_ready;
    svpd_act_t             act_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_supply_reg <= INV_SUPPLY_RST;
            carrier_period_reg <= CARRIER_PERIOD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_INV_SUPPLY: inv_supply_reg <= cfg_data;
                REG_CARRIER_PERIOD: carrier_period_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg.inv_supply = inv_supply_reg;
    assign cfg.carrier_period = carrier_period_reg;

    svpd_fold #(
        .ANGLE_BITS(ANGLE_BITS)
    ) u_fold (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .cmd(cmd),
        .out_valid(fold_valid),
        .out_ready(fold_ready),
        .sector(fold_sector),
        .r(fold_r),
        .mag(fold_mag)
    );

    svpd_sine #(
        .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
        .ANGLE_BITS(ANGLE_BITS)
    ) u_sine (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(fold_valid),
        .in_ready(fold_ready),
        .sector(fold_sector),
        .r(fold_r),
        .mag(fold_mag),
        .out_valid(sine_valid),
        .out_ready(sine_ready),
        .sine(sine_word)
    );

    svpd_active u_active (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg),
        .in_valid(sine_valid),
        .in_ready(sine_ready),
        .sine(sine_word),
        .out_valid(act_valid),
        .out_ready(act_ready),
        .act(act_word)
    );

    svpd_duty u_duty (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg),
        .in_valid(act_valid),
        .in_ready(act_ready),
        .act(act_word),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .duty(duty)
    );

`ifndef SYNTHESIS
    a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("pipeline blocks input with an empty output stage");
`endif

endmodule

>>> src/svpd_fold.sv
module svpd_fold #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  svpd_pkg::svpd_cmd_t     cmd,
    output logic                    out_valid,
    input  logic                    out_ready,
    output svpd_pkg::sector_t       sector,
    output logic [ANGLE_BITS-1:0]   r,
    output logic [15:0]             mag
);
    import svpd_pkg::*;

    localparam int AB = ANGLE_BITS;
    localparam logic [AB-1:0] HALF = {1'b1, {(AB-1){1'b0}}};
    localparam logic [AB-1:0] QUARTER = {2'b01, {(AB-2){1'b0}}};

    logic            vld_reg;
    logic            en;
    logic            neg;
    logic [AB-1:0]   a0;
    logic [AB-1:0]   a1;
    logic [AB+2:0]   six;
    sector_t         sector_reg, sector_next;
    logic [AB-1:0]   r_reg, r_next;
    logic [15:0]     mag_reg, mag_next;

    assign en = !vld_reg || out_ready;
    assign in_ready = en;

    always_comb
    begin
        neg = cmd.uq[15];
        a0 = AB'(cmd.angle);
        mag_next = neg ? 16'(~cmd.uq + 16'sd1) : 16'(cmd.uq);
        a1 = a0 + (neg ? HALF : '0) + QUARTER;
        six = (AB+3)'(a1) * (AB+3)'(6);
        sector_next = sector_t'(six[AB+2:AB]);
        r_next = six[AB-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            sector_reg <= sector_next;
            r_reg <= r_next;
            mag_reg <= mag_next;
        end
    end

    assign out_valid = vld_reg;
    assign sector = sector_reg;
    assign r = r_reg;
    assign mag = mag_reg;

endmodule

>>> src/svpd_sine.sv
module svpd_sine #(
    parameter int SINE_TABLE_DEPTH = 256,
    parameter int ANGLE_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  svpd_pkg::sector_t       sector,
    input  logic [ANGLE_BITS-1:0]   r,
    input  logic [15:0]             mag,
    output logic                    out_valid,
    input  logic                    out_ready,
    output svpd_pkg::svpd_sine_t    sine
);
    import svpd_pkg::*;

    localparam int AB = ANGLE_BITS;
    localparam int STEP = 2 * SINE_TABLE_DEPTH;
    localparam int STEP_W = $clog2(STEP + 1);
    localparam int QW = STEP_W;
    localparam int NUM_W = AB + 1 + STEP_W;
    localparam int IW = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int KQ = QW + 2;
    localparam int RQ = ((1 << KQ) + 2) / 3;
    localparam int FRAC_W = AB + 2;
    localparam int V_W = SIN_W + 2;
    localparam int K3 = V_W + 2;
    localparam int R3 = ((1 << K3) + 2) / 3;
    localparam logic [63:0] ROM_DEN = 64'(2 * SINE_TABLE_DEPTH);
    localparam logic [AB:0] TURN = {1'b1, {AB{1'b0}}};

    typedef logic [SIN_W-1:0] rom_t [0:SINE_TABLE_DEPTH];

    function automatic rom_t build_rom();
        rom_t        rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        for (int i = 0; i <= SINE_TABLE_DEPTH; i++)
        begin
            x = (64'(i) * 64'(PI_Q30)) / ROM_DEN;
            x2 = (x * x) >> 30;
            term = x;
            sum = x;
            term = ((term * x2) >> 30) / 64'd6;
            sum = sum - term;
            term = ((term * x2) >> 30) / 64'd20;
            sum = sum + term;
            term = ((term * x2) >> 30) / 64'd42;
            sum = sum - term;
            term = ((term * x2) >> 30) / 64'd72;
            sum = sum + term;
            term = ((term * x2) >> 30) / 64'd110;
            sum = sum - term;
            term = ((term * x2) >> 30) / 64'd156;
            sum = sum + term;
            term = ((term * x2) >> 30) / 64'd210;
            sum = sum - term;
            term = ((term * x2) >> 30) / 64'd272;
            sum = sum + term;
            v = (sum + 64'd8192) >> 14;
            rom[i] = (v > 64'(ONE_Q16)) ? ONE_Q16 : v[SIN_W-1:0];
        end
        return rom;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    logic a_vld_reg, b_vld_reg, c_vld_reg, d_vld_reg;
    logic a_en, b_en, c_en, d_en;

    sector_t a_sector_reg, b_sector_reg, c_sector_reg;
    logic [15:0] a_mag_reg, b_mag_reg, c_mag_reg;

    logic [QW-1:0]     a_q_reg [2], a_q_next [2];
    logic [AB-1:0]     a_nl_reg [2], a_nl_next [2];
    logic [SIN_W-1:0]  b_lo_reg [2], b_lo_next [2];
    logic [SIN_W-1:0]  b_hi_reg [2], b_hi_next [2];
    logic [FRAC_W-1:0] b_frac_reg [2], b_frac_next [2];
    logic [V_W-1:0]    c_v_reg [2], c_v_next [2];
    logic [SIN_W-1:0]  c_lo_reg [2];
    logic [SIN_W-1:0]  d_sin_next [2];
    svpd_sine_t        d_out_reg;

    logic [NUM_W-1:0]     t_ext [2];
    logic [NUM_W-1:0]     num [2];
    logic [QW+KQ-1:0]     qprod [2];
    logic [IW-1:0]        idx [2];
    logic [QW-1:0]        rem_full [2];
    logic [SIN_W-1:0]     diff [2];
    logic [SIN_W+FRAC_W-1:0] vprod [2];
    logic [V_W+K3-1:0]    p3 [2];

    assign d_en = !d_vld_reg || out_ready;
    assign c_en = !c_vld_reg || d_en;
    assign b_en = !b_vld_reg || c_en;
    assign a_en = !a_vld_reg || b_en;
    assign in_ready = a_en;

    always_comb
    begin
        t_ext[0] = NUM_W'(TURN - {1'b0, r});
        t_ext[1] = NUM_W'(r);
        for (int l = 0; l < 2; l++)
        begin
            num[l] = t_ext[l] * NUM_W'(STEP);
            a_q_next[l] = num[l][AB+QW-1:AB];
            a_nl_next[l] = num[l][AB-1:0];

            qprod[l] = (QW+KQ)'(a_q_reg[l]) * (QW+KQ)'(RQ);
            idx[l] = qprod[l][KQ+IW-1:KQ];
            rem_full[l] = a_q_reg[l] - QW'(idx[l]) * QW'(3);
            b_frac_next[l] = {rem_full[l][1:0], a_nl_reg[l]};
            b_lo_next[l] = SINE_ROM[idx[l]];
            b_hi_next[l] = SINE_ROM[IW'(idx[l] + 1'b1)];

            diff[l] = b_hi_reg[l] - b_lo_reg[l];
            vprod[l] = (SIN_W+FRAC_W)'(diff[l]) * (SIN_W+FRAC_W)'(b_frac_reg[l]);
            c_v_next[l] = vprod[l][SIN_W+FRAC_W-1:AB];

            p3[l] = (V_W+K3)'(c_v_reg[l]) * (V_W+K3)'(R3);
            d_sin_next[l] = c_lo_reg[l] + p3[l][K3+SIN_W-1:K3];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
        end
        else
        begin
            if (a_en)
            begin
                a_vld_reg <= in_valid;
            end
            if (b_en)
            begin
                b_vld_reg <= a_vld_reg;
            end
            if (c_en)
            begin
                c_vld_reg <= b_vld_reg;
            end
            if (d_en)
            begin
                d_vld_reg <= c_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_en && in_valid)
        begin
            a_sector_reg <= sector;
            a_mag_reg <= mag;
            a_q_reg <= a_q_next;
            a_nl_reg <= a_nl_next;
        end
        if (b_en && a_vld_reg)
        begin
            b_sector_reg <= a_sector_reg;
            b_mag_reg <= a_mag_reg;
            b_lo_reg <= b_lo_next;
            b_hi_reg <= b_hi_next;
            b_frac_reg <= b_frac_next;
        end
        if (c_en && b_vld_reg)
        begin
            c_sector_reg <= b_sector_reg;
            c_mag_reg <= b_mag_reg;
            c_v_reg <= c_v_next;
            c_lo_reg <= b_lo_reg;
        end
        if (d_en && c_vld_reg)
        begin
            d_out_reg.sector <= c_sector_reg;
            d_out_reg.mag <= c_mag_reg;
            d_out_reg.sin_t1 <= d_sin_next[0];
            d_out_reg.sin_t2 <= d_sin_next[1];
        end
    end

    assign out_valid = d_vld_reg;
    assign sine = d_out_reg;

`ifndef SYNTHESIS
    a_sine_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (sine.sin_t1 <= ONE_Q16) && (sine.sin_t2 <= ONE_Q16))
        else $error("sine lane above unity");
`endif

endmodule

>>> src/svpd_active.sv
module svpd_active (
    input  logic                    clk,
    input  logic                    rst_n,
    input  svpd_pkg::svpd_cfg_t     cfg,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  svpd_pkg::svpd_sine_t    sine,
    output logic                    out_valid,
    input  logic                    out_ready,
    output svpd_pkg::svpd_act_t     act
);
    import svpd_pkg::*;

    localparam int SCL_PROD_W = PROD_W + 16;
    localparam int ACT_PROD_W = SCL_W + 17;

    logic e_vld_reg, f_vld_reg, g_vld_reg;
    logic e_en, f_en, g_en;

    sector_t e_sector_reg, f_sector_reg;
    logic [PROD_W-1:0] e_p_reg [2], e_p_next [2];
    logic [SCL_W-1:0]  f_p_reg [2], f_p_next [2];
    logic [ACT_W-1:0]  g_t_next [2];
    svpd_act_t         g_out_reg;

    logic [SIN_W-1:0]      sin_in [2];
    logic [SCL_PROD_W-1:0] sprod [2];
    logic [ACT_PROD_W-1:0] tprod [2];

    assign g_en = !g_vld_reg || out_ready;
    assign f_en = !f_vld_reg || g_en;
    assign e_en = !e_vld_reg || f_en;
    assign in_ready = e_en;

    always_comb
    begin
        sin_in[0] = sine.sin_t1;
        sin_in[1] = sine.sin_t2;
        for (int l = 0; l < 2; l++)
        begin
            e_p_next[l] = PROD_W'(sin_in[l]) * PROD_W'(sine.mag);
            sprod[l] = SCL_PROD_W'(e_p_reg[l]) * SCL_PROD_W'(cfg.inv_supply);
            f_p_next[l] = sprod[l][SCL_PROD_W-1:24];
            tprod[l] = ACT_PROD_W'(f_p_reg[l]) * ACT_PROD_W'(SQRT3_Q16);
            g_t_next[l] = tprod[l][ACT_PROD_W-1:16];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_vld_reg <= 1'b0;
            f_vld_reg <= 1'b0;
            g_vld_reg <= 1'b0;
        end
        else
        begin
            if (e_en)
            begin
                e_vld_reg <= in_valid;
            end
            if (f_en)
            begin
                f_vld_reg <= e_vld_reg;
            end
            if (g_en)
            begin
                g_vld_reg <= f_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (e_en && in_valid)
        begin
            e_sector_reg <= sine.sector;
            e_p_reg <= e_p_next;
        end
        if (f_en && e_vld_reg)
        begin
            f_sector_reg <= e_sector_reg;
            f_p_reg <= f_p_next;
        end
        if (g_en && f_vld_reg)
        begin
            g_out_reg.sector <= f_sector_reg;
            g_out_reg.t1 <= g_t_next[0];
            g_out_reg.t2 <= g_t_next[1];
        end
    end

    assign out_valid = g_vld_reg;
    assign act = g_out_reg;

endmodule

>>> src/svpd_duty.sv
module svpd_duty (
    input  logic                    clk,
    input  logic                    rst_n,
    input  svpd_pkg::svpd_cfg_t     cfg,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  svpd_pkg::svpd_act_t     act,
    output logic                    out_valid,
    input  logic                    out_ready,
    output svpd_pkg::svpd_duty_t    duty
);
    import svpd_pkg::*;

    localparam int S_W = ACT_W + 3;
    localparam int DP_W = DUTY2_W + 16;
    localparam logic signed [S_W-1:0] ONE_S = S_W'(ONE_Q16);
    localparam logic signed [S_W-1:0] TWO_S = S_W'(ONE_Q16) <<< 1;
    localparam logic [DUTY2_W-1:0] TWO_U = DUTY2_W'(ONE_Q16) << 1;

    function automatic logic [DUTY2_W-1:0] clamp2(input logic signed [S_W-1:0] d);
        logic [DUTY2_W-1:0] res;
        if (d < 0)
        begin
            res = '0;
        end
        else if (d > TWO_S)
        begin
            res = TWO_U;
        end
        else
        begin
            res = d[DUTY2_W-1:0];
        end
        return res;
    endfunction

    logic h_vld_reg, k_vld_reg;
    logic h_en, k_en;

    logic signed [S_W-1:0] t1s, t2s;
    logic signed [S_W-1:0] full, pos1, pos2, zero;
    logic signed [S_W-1:0] sa, sb, sc;
    logic [DUTY2_W-1:0] h_d_reg [3], h_d_next [3];
    logic [DP_W-1:0]    dprod [3];
    svpd_duty_t         k_out_reg, k_out_next;

    assign k_en = !k_vld_reg || out_ready;
    assign h_en = !h_vld_reg || k_en;
    assign in_ready = h_en;

    always_comb
    begin
        t1s = S_W'(act.t1);
        t2s = S_W'(act.t2);
        full = ONE_S + t1s + t2s;
        pos1 = ONE_S + t1s - t2s;
        pos2 = ONE_S - t1s + t2s;
        zero = ONE_S - t1s - t2s;
        case (act.sector)
            SEC_1:
            begin
                sa = full; sb = pos2; sc = zero;
            end
            SEC_2:
            begin
                sa = pos1; sb = full; sc = zero;
            end
            SEC_3:
            begin
                sa = zero; sb = full; sc = pos2;
            end
            SEC_4:
            begin
                sa = zero; sb = pos1; sc = full;
            end
            SEC_5:
            begin
                sa = pos2; sb = zero; sc = full;
            end
            SEC_6:
            begin
                sa = full; sb = zero; sc = pos1;
            end
            default:
            begin
                sa = '0; sb = '0; sc = '0;
            end
        endcase
        h_d_next[0] = clamp2(sa);
        h_d_next[1] = clamp2(sb);
        h_d_next[2] = clamp2(sc);
        for (int p = 0; p < 3; p++)
        begin
            dprod[p] = DP_W'(h_d_reg[p]) * DP_W'(cfg.carrier_period);
        end
        k_out_next.duty_a = dprod[0][32:17];
        k_out_next.duty_b = dprod[1][32:17];
        k_out_next.duty_c = dprod[2][32:17];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_vld_reg <= 1'b0;
            k_vld_reg <= 1'b0;
        end
        else
        begin
            if (h_en)
            begin
                h_vld_reg <= in_valid;
            end
            if (k_en)
            begin
                k_vld_reg <= h_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (h_en && in_valid)
        begin
            h_d_reg <= h_d_next;
        end
        if (k_en && h_vld_reg)
        begin
            k_out_reg <= k_out_next;
        end
    end

    assign out_valid = k_vld_reg;
    assign duty = k_out_reg;

`ifndef SYNTHESIS
    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (duty.duty_a <= cfg.carrier_period)
            && (duty.duty_b <= cfg.carrier_period)
            && (duty.duty_c <= cfg.carrier_period))
        else $error("compare value above period");
`endif

endmodule
